// File: rtl/core/apf_mod_pkg.sv
`timescale 1ns / 1ps

package apf_mod_pkg;

    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int BITS_PER_WORD_DEF  = 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_DATA_BYTE       = 3'd0,
        REG_SAMPLES_PER_BIT = 3'd1,
        REG_CARRIER_STEP    = 3'd2,
        REG_FSK_STEP_ZERO   = 3'd3,
        REG_FSK_STEP_ONE    = 3'd4,
        REG_GAIN_ZERO       = 3'd5
    } cfg_reg_t;

    localparam logic [7:0]  DATA_BYTE_RST       = 8'd66;
    localparam logic [15:0] SAMPLES_PER_BIT_RST = 16'd7143;
    localparam logic [31:0] CARRIER_STEP_RST    = 32'd60129542;
    localparam logic [31:0] FSK_STEP_ZERO_RST   = 32'd60730838;
    localparam logic [31:0] FSK_STEP_ONE_RST    = 32'd61332133;
    localparam logic [14:0] GAIN_ZERO_RST       = 15'd16384;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;

    // sin(q/quarter * pi/2) * 32767, Taylor series to 13th order in Q30
    function automatic logic [14:0] quarter_sine(input logic [14:0] q, input int abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] sum;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] v;
        x   = (64'(q) * HALF_PI_Q30) >> (abits - 2);
        x2  = (x * x) >> 30;
        sum = x;
        mag = x;
        for (int n = 1; n <= 6; n++) begin
            prod = (mag * x2) >> 30;
            unique case (n)
                1: mag = prod / 64'd6;
                2: mag = prod / 64'd20;
                3: mag = prod / 64'd42;
                4: mag = prod / 64'd72;
                5: mag = prod / 64'd110;
                default: mag = prod / 64'd156;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - mag;
            end else begin
                sum = sum + mag;
            end
        end
        v = (sum * FULL_SCALE + (64'd1 << 29)) >> 30;
        if (v > FULL_SCALE) begin
            v = FULL_SCALE;
        end
        return v[14:0];
    endfunction

    function automatic logic signed [15:0] sine_entry(input int k, input int abits);
        int          quarter;
        int          quad;
        int          r;
        logic [14:0] s;
        quarter = 1 << (abits - 2);
        quad    = (k >> (abits - 2)) & 3;
        r       = k & (quarter - 1);
        if ((quad & 1) != 0) begin
            s = quarter_sine(15'(quarter - r), abits);
        end else begin
            s = quarter_sine(15'(r), abits);
        end
        if ((quad & 2) != 0) begin
            return -$signed({1'b0, s});
        end else begin
            return $signed({1'b0, s});
        end
    endfunction

endpackage

// File: rtl/core/ask_psk_fsk_modulator.sv
`timescale 1ns / 1ps

// Binary ASK / PSK / FSK modulator.
// Input channel (s_axis): one item per output sample; tdata bit 0 is restart,
// which clears the three carrier phases and the bit position before the
// sample is formed. Output channel (m_axis): one item per input item, holding
// the amplitude, phase and frequency keyed samples (Q1.15), the keying bit and
// its position; tlast marks the final sample of the word's last bit.
// Registers are written through cfg_we / cfg_addr / cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
// Each item passes the ROM read stage, then gain multiply and output register.
// Throughput: one item per cycle unless stalled; the dual-port sine ROM serves
// the carrier and the selected FSK tone in the same cycle.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// phases, bit position and sample count, and empties the pipeline.
// When m_axis_tready is low a valid output item holds; an empty ROM stage still
// takes one more item, after which s_axis_tready drops until the output drains.
module ask_psk_fsk_modulator #(
    parameter int SINE_ADDR_BITS = apf_mod_pkg::SINE_ADDR_BITS_DEF,
    parameter int BITS_PER_WORD  = apf_mod_pkg::BITS_PER_WORD_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [apf_mod_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [apf_mod_pkg::CFG_DATA_W-1:0] cfg_wdata,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [0] restart

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] ask_sample, [31:16] psk_sample, [47:32] fsk_sample,
    // [48] data_bit, [51:49] bit_position
    output logic [55:0]                        m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
    localparam int IDX_W     = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
    localparam int POS_W     = (IDX_W > 3) ? IDX_W : 3;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BITS_PER_WORD - 1);

    // configuration
    logic [7:0]  data_byte_reg;
    logic [15:0] samples_per_bit_reg;
    logic [31:0] carrier_step_reg;
    logic [31:0] fsk_step_zero_reg;
    logic [31:0] fsk_step_one_reg;
    logic [14:0] gain_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_byte_reg       <= apf_mod_pkg::DATA_BYTE_RST;
            samples_per_bit_reg <= apf_mod_pkg::SAMPLES_PER_BIT_RST;
            carrier_step_reg    <= apf_mod_pkg::CARRIER_STEP_RST;
            fsk_step_zero_reg   <= apf_mod_pkg::FSK_STEP_ZERO_RST;
            fsk_step_one_reg    <= apf_mod_pkg::FSK_STEP_ONE_RST;
            gain_zero_reg       <= apf_mod_pkg::GAIN_ZERO_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                apf_mod_pkg::REG_DATA_BYTE:       data_byte_reg       <= cfg_wdata[7:0];
                apf_mod_pkg::REG_SAMPLES_PER_BIT: samples_per_bit_reg <= cfg_wdata[15:0];
                apf_mod_pkg::REG_CARRIER_STEP:    carrier_step_reg    <= cfg_wdata;
                apf_mod_pkg::REG_FSK_STEP_ZERO:   fsk_step_zero_reg   <= cfg_wdata;
                apf_mod_pkg::REG_FSK_STEP_ONE:    fsk_step_one_reg    <= cfg_wdata;
                apf_mod_pkg::REG_GAIN_ZERO:       gain_zero_reg       <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // sine ROM, full period
    logic signed [15:0] sine_rom [SINE_SIZE];

    for (genvar k = 0; k < SINE_SIZE; k++) begin : g_rom
        assign sine_rom[k] = apf_mod_pkg::sine_entry(k, SINE_ADDR_BITS);
    end

    // handshake and stage enables
    logic s1_valid_reg;
    logic out_valid_reg;
    logic en_out;
    logic en_s1;
    logic accept;

    assign en_out        = !out_valid_reg || m_axis_tready;
    assign en_s1         = !s1_valid_reg || en_out;
    assign s_axis_tready = en_s1;
    assign accept        = s_axis_tvalid && en_s1;

    // modulator state
    logic [31:0]      carrier_phase_reg, carrier_phase_next;
    logic [31:0]      tone_zero_phase_reg, tone_zero_phase_next;
    logic [31:0]      tone_one_phase_reg, tone_one_phase_next;
    logic [IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [15:0]      sample_in_bit_reg, sample_in_bit_next;

    logic             restart;
    logic [31:0]      cur_carrier;
    logic [31:0]      cur_tone_zero;
    logic [31:0]      cur_tone_one;
    logic [IDX_W-1:0] cur_idx;
    logic [15:0]      cur_sib;
    logic [POS_W-1:0] idx_ext;
    logic             cur_bit;
    logic [15:0]      hold;
    logic [16:0]      sib_inc;
    logic             ends_bit;
    logic             cur_last;
    logic [SINE_ADDR_BITS-1:0] addr_c;
    logic [SINE_ADDR_BITS-1:0] addr_f;

    always_comb begin
        restart       = s_axis_tdata[0];
        cur_carrier   = restart ? 32'd0 : carrier_phase_reg;
        cur_tone_zero = restart ? 32'd0 : tone_zero_phase_reg;
        cur_tone_one  = restart ? 32'd0 : tone_one_phase_reg;
        cur_idx       = restart ? '0 : bit_index_reg;
        cur_sib       = restart ? 16'd0 : sample_in_bit_reg;

        idx_ext = POS_W'(cur_idx);
        cur_bit = (32'(idx_ext) < 32'd8) ? data_byte_reg[idx_ext[2:0]] : 1'b0;

        hold     = (samples_per_bit_reg == 16'd0) ? 16'd1 : samples_per_bit_reg;
        sib_inc  = {1'b0, cur_sib} + 17'd1;
        ends_bit = sib_inc >= {1'b0, hold};
        cur_last = ends_bit && (cur_idx == LAST_IDX);

        addr_c = cur_carrier[31 -: SINE_ADDR_BITS];
        addr_f = cur_bit ? cur_tone_one[31 -: SINE_ADDR_BITS]
                         : cur_tone_zero[31 -: SINE_ADDR_BITS];

        carrier_phase_next   = cur_carrier + carrier_step_reg;
        tone_zero_phase_next = cur_tone_zero + fsk_step_zero_reg;
        tone_one_phase_next  = cur_tone_one + fsk_step_one_reg;
        if (ends_bit) begin
            sample_in_bit_next = 16'd0;
            bit_index_next     = cur_last ? '0 : cur_idx + IDX_W'(1);
        end else begin
            sample_in_bit_next = sib_inc[15:0];
            bit_index_next     = cur_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carrier_phase_reg   <= '0;
            tone_zero_phase_reg <= '0;
            tone_one_phase_reg  <= '0;
            bit_index_reg       <= '0;
            sample_in_bit_reg   <= '0;
        end else if (accept) begin
            carrier_phase_reg   <= carrier_phase_next;
            tone_zero_phase_reg <= tone_zero_phase_next;
            tone_one_phase_reg  <= tone_one_phase_next;
            bit_index_reg       <= bit_index_next;
            sample_in_bit_reg   <= sample_in_bit_next;
        end
    end

    // stage 1: ROM read
    logic signed [15:0] sine_c_reg;
    logic signed [15:0] sine_f_reg;
    logic               s1_bit_reg;
    logic [2:0]         s1_pos_reg;
    logic               s1_last_reg;

    always_ff @(posedge aclk) begin
        if (en_s1) begin
            sine_c_reg  <= sine_rom[addr_c];
            sine_f_reg  <= sine_rom[addr_f];
            s1_bit_reg  <= cur_bit;
            s1_pos_reg  <= idx_ext[2:0];
            s1_last_reg <= cur_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en_s1) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    // stage 2: gain, keying, output register
    logic [14:0]        mag;
    logic [29:0]        mag_prod;
    logic [30:0]        mag_round;
    logic [14:0]        mag_scaled;
    logic signed [15:0] ask_next;
    logic signed [15:0] psk_next;
    logic signed [15:0] ask_reg;
    logic signed [15:0] psk_reg;
    logic signed [15:0] fsk_reg;
    logic               bit_reg;
    logic [2:0]         pos_reg;
    logic               last_reg;

    always_comb begin
        mag        = sine_c_reg[15] ? 15'(-sine_c_reg) : sine_c_reg[14:0];
        mag_prod   = 30'(mag) * 30'(gain_zero_reg);
        mag_round  = {1'b0, mag_prod} + 31'(1 << 14);
        mag_scaled = mag_round[29:15];
        if (s1_bit_reg) begin
            ask_next = sine_c_reg;
            psk_next = -sine_c_reg;
        end else begin
            ask_next = sine_c_reg[15] ? -$signed({1'b0, mag_scaled})
                                      : $signed({1'b0, mag_scaled});
            psk_next = sine_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            ask_reg  <= ask_next;
            psk_reg  <= psk_next;
            fsk_reg  <= sine_f_reg;
            bit_reg  <= s1_bit_reg;
            pos_reg  <= s1_pos_reg;
            last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en_out) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, pos_reg, bit_reg, fsk_reg, psk_reg, ask_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// File: test/tb_ask_psk_fsk_modulator.sv
`timescale 1ns / 1ps

module tb_ask_psk_fsk_modulator;

    localparam int SINE_BITS      = apf_mod_pkg::SINE_ADDR_BITS_DEF;
    localparam int SINE_SIZE      = 1 << SINE_BITS;
    localparam int QUARTER        = 1 << (SINE_BITS - 2);
    localparam int ITEM_TARGET    = 1900;
    localparam int WATCHDOG_LIMIT = 3000;

    // indexes past the register list, writes must be ignored
    localparam logic [apf_mod_pkg::CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [apf_mod_pkg::CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [15:0] ask;
        logic signed [15:0] psk;
        logic signed [15:0] fsk;
        logic               data_bit;
        logic [2:0]         bit_pos;
        logic               ends_word;
    } keyed_sample_t;

    typedef struct {
        logic [apf_mod_pkg::CFG_ADDR_W-1:0] addr;
        logic [apf_mod_pkg::CFG_DATA_W-1:0] value;
    } reg_write_t;

    class sample_scoreboard;
        logic signed [15:0] sine_rom [SINE_SIZE];
        logic [7:0]         data_byte;
        logic [15:0]        samples_per_bit;
        logic [31:0]        carrier_step;
        logic [31:0]        tone0_step;
        logic [31:0]        tone1_step;
        logic [14:0]        gain_zero;
        logic [31:0]        carrier_ph;
        logic [31:0]        tone0_ph;
        logic [31:0]        tone1_ph;
        logic [2:0]         bit_idx;
        logic [15:0]        sample_cnt;
        keyed_sample_t      sample_q[$];
        int                 errors;

        function new();
            int quad;
            int r;
            int mag;
            for (int k = 0; k < SINE_SIZE; k++) begin
                quad = (k >> (SINE_BITS - 2)) & 3;
                r    = k & (QUARTER - 1);
                mag  = (quad & 1) ? quarter_wave(QUARTER - r) : quarter_wave(r);
                sine_rom[k] = (quad & 2) ? 16'(-mag) : 16'(mag);
            end
            data_byte       = apf_mod_pkg::DATA_BYTE_RST;
            samples_per_bit = apf_mod_pkg::SAMPLES_PER_BIT_RST;
            carrier_step    = apf_mod_pkg::CARRIER_STEP_RST;
            tone0_step      = apf_mod_pkg::FSK_STEP_ZERO_RST;
            tone1_step      = apf_mod_pkg::FSK_STEP_ONE_RST;
            gain_zero       = apf_mod_pkg::GAIN_ZERO_RST;
            carrier_ph      = '0;
            tone0_ph        = '0;
            tone1_ph        = '0;
            bit_idx         = '0;
            sample_cnt      = '0;
            errors          = 0;
        endfunction

        // Taylor series of sin over one quarter turn in Q30, scaled to 32767
        function int quarter_wave(int q);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned acc;
            longint unsigned term;
            x    = (64'(q) * 64'd1686629713) >> (SINE_BITS - 2);
            x2   = (x * x) >> 30;
            acc  = x;
            term = x;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            acc = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
            if (acc > 64'd32767) begin
                acc = 64'd32767;
            end
            return int'(acc);
        endfunction

        function void set_reg(logic [apf_mod_pkg::CFG_ADDR_W-1:0] addr,
                              logic [apf_mod_pkg::CFG_DATA_W-1:0] value);
            case (addr)
                apf_mod_pkg::REG_DATA_BYTE:       data_byte       = value[7:0];
                apf_mod_pkg::REG_SAMPLES_PER_BIT: samples_per_bit = value[15:0];
                apf_mod_pkg::REG_CARRIER_STEP:    carrier_step    = value;
                apf_mod_pkg::REG_FSK_STEP_ZERO:   tone0_step      = value;
                apf_mod_pkg::REG_FSK_STEP_ONE:    tone1_step      = value;
                apf_mod_pkg::REG_GAIN_ZERO:       gain_zero       = value[14:0];
                default:                          ;
            endcase
        endfunction

        function void predict_sample(logic restart);
            keyed_sample_t      e;
            logic signed [15:0] s;
            int                 mag;
            int unsigned        hold;
            logic               ends_bit;
            if (restart) begin
                carrier_ph = '0;
                tone0_ph   = '0;
                tone1_ph   = '0;
                bit_idx    = '0;
                sample_cnt = '0;
            end
            e.data_bit = data_byte[bit_idx];
            s = sine_rom[carrier_ph[31 -: SINE_BITS]];
            if (e.data_bit) begin
                e.ask = s;
                e.psk = -s;
                e.fsk = sine_rom[tone1_ph[31 -: SINE_BITS]];
            end else begin
                mag   = (s < 0) ? -int'(s) : int'(s);
                mag   = (mag * int'(gain_zero) + 16384) >>> 15;
                e.ask = (s < 0) ? 16'(-mag) : 16'(mag);
                e.psk = s;
                e.fsk = sine_rom[tone0_ph[31 -: SINE_BITS]];
            end
            hold        = (samples_per_bit == 16'd0) ? 1 : 32'(samples_per_bit);
            ends_bit    = (32'(sample_cnt) + 1) >= hold;
            e.bit_pos   = bit_idx;
            e.ends_word = ends_bit && (bit_idx == 3'd7);
            sample_q.push_back(e);
            carrier_ph = carrier_ph + carrier_step;
            tone0_ph   = tone0_ph + tone0_step;
            tone1_ph   = tone1_ph + tone1_step;
            if (ends_bit) begin
                sample_cnt = '0;
                bit_idx    = bit_idx + 3'd1;
            end else begin
                sample_cnt = sample_cnt + 16'd1;
            end
        endfunction

        function void compare_field(string field, int expd, int got);
            if (expd != got) begin
                $error("%s: expected %0d, actual %0d", field, expd, got);
                errors++;
            end
        endfunction

        function void check_sample(logic [55:0] tdata, logic tlast);
            keyed_sample_t e;
            if (sample_q.size() == 0) begin
                $error("result item with no expected sample waiting");
                errors++;
                return;
            end
            e = sample_q.pop_front();
            compare_field("ask_sample", e.ask, $signed(tdata[15:0]));
            compare_field("psk_sample", e.psk, $signed(tdata[31:16]));
            compare_field("fsk_sample", e.fsk, $signed(tdata[47:32]));
            compare_field("data_bit", e.data_bit, tdata[48]);
            compare_field("bit_position", e.bit_pos, tdata[51:49]);
            compare_field("last_sample", e.ends_word, tlast);
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_we;
    logic [apf_mod_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [apf_mod_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                               s_axis_tvalid;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata;   // [0] restart
    logic                               m_axis_tvalid;
    logic                               m_axis_tready;
    // [15:0] ask_sample, [31:16] psk_sample, [47:32] fsk_sample,
    // [48] data_bit, [51:49] bit_position
    logic [55:0]                        m_axis_tdata;
    logic                               m_axis_tlast;

    sample_scoreboard sb = new();
    int               items_sent = 0;
    int               quiet_cycles = 0;

    ask_psk_fsk_modulator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic send_item(input logic restart, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_axis_tready);
        sb.predict_sample(restart);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.sample_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_regs(input reg_write_t list[$]);
        foreach (list[i]) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= list[i].addr;
            cfg_wdata <= list[i].value;
            @(posedge aclk);
            sb.set_reg(list[i].addr, list[i].value);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_step();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_hold();
        logic [31:0] upper;
        upper = $urandom() & 32'hFFFF_0000;
        case ($urandom_range(0, 9))
            0:       return upper;
            1:       return upper | 32'(16'hFFFF);
            2:       return upper | $urandom_range(13, 300);
            default: return upper | $urandom_range(1, 12);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_7FFF;
            default: return $urandom();
        endcase
    endfunction

    // sender
    initial begin
        reg_write_t wr[$];
        int         n_items;
        logic       steady;
        logic       restart;
        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= apf_mod_pkg::REG_DATA_BYTE;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults after reset
        send_item(1'b0, $urandom_range(0, 19));
        send_item(1'b0, $urandom_range(0, 19));
        send_item(1'b1, $urandom_range(0, 19));
        send_item(1'b0, $urandom_range(0, 19));
        wait_idle();

        // zero hold acts as one sample per bit; wide writes are masked
        wr.delete();
        wr.push_back('{apf_mod_pkg::REG_DATA_BYTE, 32'hFFFF_FFA5});
        wr.push_back('{apf_mod_pkg::REG_SAMPLES_PER_BIT, 32'hFFFF_0000});
        wr.push_back('{apf_mod_pkg::REG_CARRIER_STEP, 32'hFFFF_FFFF});
        wr.push_back('{apf_mod_pkg::REG_FSK_STEP_ZERO, 32'h0000_0000});
        wr.push_back('{apf_mod_pkg::REG_FSK_STEP_ONE, 32'h8000_0000});
        wr.push_back('{apf_mod_pkg::REG_GAIN_ZERO, 32'hFFFF_FFFF});
        wr.push_back('{REG_SPARE_6, $urandom()});
        wr.push_back('{REG_SPARE_7, $urandom()});
        write_regs(wr);
        send_item(1'b1, 0);
        for (int i = 0; i < 8; i++) begin
            send_item(1'b0, $urandom_range(0, 3));
        end
        wait_idle();

        // all-zero byte at zero gain
        wr.delete();
        wr.push_back('{apf_mod_pkg::REG_DATA_BYTE, 32'h0000_0000});
        wr.push_back('{apf_mod_pkg::REG_GAIN_ZERO, 32'h0000_0000});
        wr.push_back('{apf_mod_pkg::REG_SAMPLES_PER_BIT, 32'd2});
        wr.push_back('{apf_mod_pkg::REG_CARRIER_STEP, 32'h0200_0000});
        write_regs(wr);
        send_item(1'b1, 0);
        for (int i = 0; i < 3; i++) begin
            send_item(1'b0, 0);
        end
        wait_idle();

        // hold cut below the running count ends the bit at once
        wr.delete();
        wr.push_back('{apf_mod_pkg::REG_DATA_BYTE, 32'h0000_005A});
        wr.push_back('{apf_mod_pkg::REG_SAMPLES_PER_BIT, 32'd20});
        wr.push_back('{apf_mod_pkg::REG_GAIN_ZERO, $urandom()});
        write_regs(wr);
        for (int i = 0; i < 6; i++) begin
            send_item(1'b0, $urandom_range(0, 19));
        end
        wait_idle();
        wr.delete();
        wr.push_back('{apf_mod_pkg::REG_SAMPLES_PER_BIT, 32'd3});
        write_regs(wr);
        for (int i = 0; i < 4; i++) begin
            send_item(1'b0, $urandom_range(0, 19));
        end

        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            wr.delete();
            if ($urandom_range(0, 1)) begin
                wr.push_back('{apf_mod_pkg::REG_DATA_BYTE, $urandom()});
            end
            if ($urandom_range(0, 1)) begin
                wr.push_back('{apf_mod_pkg::REG_SAMPLES_PER_BIT, rand_hold()});
            end
            if ($urandom_range(0, 1)) begin
                wr.push_back('{apf_mod_pkg::REG_CARRIER_STEP, rand_step()});
            end
            if ($urandom_range(0, 1)) begin
                wr.push_back('{apf_mod_pkg::REG_FSK_STEP_ZERO, rand_step()});
            end
            if ($urandom_range(0, 1)) begin
                wr.push_back('{apf_mod_pkg::REG_FSK_STEP_ONE, rand_step()});
            end
            if ($urandom_range(0, 1)) begin
                wr.push_back('{apf_mod_pkg::REG_GAIN_ZERO, rand_gain()});
            end
            if ($urandom_range(0, 7) == 0) wr.push_back('{REG_SPARE_7, $urandom()});
            write_regs(wr);
            steady  = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(20, 200);
            for (int i = 0; i < n_items; i++) begin
                restart = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
                send_item(restart, steady ? 0 : $urandom_range(0, 19));
            end
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.sample_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // receiver: per-item stall, quiet stretches, and a long hold-off now and then
    initial begin
        int stall;
        int n_res;
        stall = 0;
        n_res = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                sb.check_sample(m_axis_tdata, m_axis_tlast);
                n_res++;
                if (n_res % 500 == 250) begin
                    stall = 300;
                end else if ((n_res / 150) % 3 == 0) begin
                    stall = 0;
                end else begin
                    stall = $urandom_range(0, 19);
                end
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// File: files.f
rtl/core/apf_mod_pkg.sv
rtl/core/ask_psk_fsk_modulator.sv
test/tb_ask_psk_fsk_modulator.sv
